// ===== rtl/core/hslp_pkg.sv =====
// Shared types and constants for the HTTP status line parser.
package hslp_pkg;

  localparam int unsigned OffsetBitsDefault = 16;
  localparam int unsigned OutOffsetBits     = 16;
  localparam int unsigned StatusBits        = 10;

  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  localparam logic [1:0] StatusDigits = 2'd3;

  typedef enum logic [3:0] {
    PhStart,
    PhH,
    PhHt,
    PhHtt,
    PhHttp,
    PhMajorFirst,
    PhMajor,
    PhMinorFirst,
    PhMinor,
    PhStatus,
    PhAfterStatus,
    PhText,
    PhAlmost
  } phase_e;

  typedef enum logic [1:0] {
    LsMore = 2'd0,
    LsDone = 2'd1,
    LsBad  = 2'd2
  } line_status_e;

  // Per-line parser context apart from the byte offsets.
  typedef struct packed {
    phase_e                  phase;
    logic [StatusBits-1:0]   status;
    logic [1:0]              count;
    logic                    end_valid;
  } ctx_t;

  // Result of one parsed byte, apart from the offsets.
  typedef struct packed {
    line_status_e            kind;
    logic [StatusBits-1:0]   code;
  } result_t;

endpackage

// ===== rtl/core/hslp_step.sv =====
// Combinational next-state and result logic for one byte of the status line.
module hslp_step #(
  parameter int unsigned OFFSET_BITS = hslp_pkg::OffsetBitsDefault
) (
  input  hslp_pkg::ctx_t           ctx_i,
  input  logic [OFFSET_BITS-1:0]   byte_off_i,
  input  logic [OFFSET_BITS-1:0]   first_off_i,
  input  logic [OFFSET_BITS-1:0]   end_off_i,
  input  logic [7:0]               data_i,
  output hslp_pkg::ctx_t           ctx_o,
  output logic [OFFSET_BITS-1:0]   byte_off_o,
  output logic [OFFSET_BITS-1:0]   first_off_o,
  output logic [OFFSET_BITS-1:0]   end_off_o,
  output hslp_pkg::result_t        result_o,
  output logic [OFFSET_BITS-1:0]   res_start_o,
  output logic [OFFSET_BITS-1:0]   res_end_o
);

  hslp_pkg::ctx_t           ctx_n;
  hslp_pkg::line_status_e   kind;
  logic [OFFSET_BITS-1:0]   first_n;
  logic [OFFSET_BITS-1:0]   end_n;
  logic                     is_digit;
  logic [13:0]              times_ten;

  assign is_digit  = (data_i inside {[hslp_pkg::ChZero:hslp_pkg::ChNine]});
  // status * 10 + digit; the low nibble of an ASCII digit is its value.
  assign times_ten = {1'b0, ctx_i.status, 3'b000} + {3'b000, ctx_i.status, 1'b0}
                   + {10'd0, data_i[3:0]};

  always_comb begin
    ctx_n   = ctx_i;
    first_n = first_off_i;
    end_n   = end_off_i;
    kind    = hslp_pkg::LsMore;
    case (ctx_i.phase)
      hslp_pkg::PhH: begin
        if (data_i == hslp_pkg::ChT) ctx_n.phase = hslp_pkg::PhHt;
        else kind = hslp_pkg::LsBad;
      end
      hslp_pkg::PhHt: begin
        if (data_i == hslp_pkg::ChT) ctx_n.phase = hslp_pkg::PhHtt;
        else kind = hslp_pkg::LsBad;
      end
      hslp_pkg::PhHtt: begin
        if (data_i == hslp_pkg::ChP) ctx_n.phase = hslp_pkg::PhHttp;
        else kind = hslp_pkg::LsBad;
      end
      hslp_pkg::PhHttp: begin
        if (data_i == hslp_pkg::ChSlash) ctx_n.phase = hslp_pkg::PhMajorFirst;
        else kind = hslp_pkg::LsBad;
      end
      hslp_pkg::PhMajorFirst: begin
        if (data_i inside {[hslp_pkg::ChOne:hslp_pkg::ChNine]}) begin
          ctx_n.phase = hslp_pkg::PhMajor;
        end else begin
          kind = hslp_pkg::LsBad;
        end
      end
      hslp_pkg::PhMajor: begin
        if (data_i == hslp_pkg::ChDot) ctx_n.phase = hslp_pkg::PhMinorFirst;
        else if (!is_digit) kind = hslp_pkg::LsBad;
      end
      hslp_pkg::PhMinorFirst: begin
        if (is_digit) ctx_n.phase = hslp_pkg::PhMinor;
        else kind = hslp_pkg::LsBad;
      end
      hslp_pkg::PhMinor: begin
        if (data_i == hslp_pkg::ChSpace) ctx_n.phase = hslp_pkg::PhStatus;
        else if (!is_digit) kind = hslp_pkg::LsBad;
      end
      hslp_pkg::PhStatus: begin
        if (data_i == hslp_pkg::ChSpace) begin
          ctx_n.phase = hslp_pkg::PhStatus;
        end else if (is_digit) begin
          if (ctx_i.count == 2'd0) first_n = byte_off_i;
          ctx_n.status = times_ten[hslp_pkg::StatusBits-1:0];
          ctx_n.count  = ctx_i.count + 2'd1;
          if (ctx_n.count == hslp_pkg::StatusDigits) ctx_n.phase = hslp_pkg::PhAfterStatus;
        end else begin
          kind = hslp_pkg::LsBad;
        end
      end
      hslp_pkg::PhAfterStatus: begin
        if (data_i == hslp_pkg::ChSpace || data_i == hslp_pkg::ChDot) begin
          ctx_n.phase = hslp_pkg::PhText;
        end else if (data_i == hslp_pkg::ChCr) begin
          ctx_n.phase     = hslp_pkg::PhAlmost;
          end_n           = byte_off_i;
          ctx_n.end_valid = 1'b1;
        end else if (data_i == hslp_pkg::ChLf) begin
          kind = hslp_pkg::LsDone;
        end else begin
          kind = hslp_pkg::LsBad;
        end
      end
      hslp_pkg::PhText: begin
        if (data_i == hslp_pkg::ChCr) begin
          ctx_n.phase     = hslp_pkg::PhAlmost;
          end_n           = byte_off_i;
          ctx_n.end_valid = 1'b1;
        end else if (data_i == hslp_pkg::ChLf) begin
          kind = hslp_pkg::LsDone;
        end
      end
      hslp_pkg::PhAlmost: begin
        if (data_i == hslp_pkg::ChLf) kind = hslp_pkg::LsDone;
        else kind = hslp_pkg::LsBad;
      end
      default: begin
        if (data_i == hslp_pkg::ChH) ctx_n.phase = hslp_pkg::PhH;
        else kind = hslp_pkg::LsBad;
      end
    endcase

    // A lone LF marks the line end when no CR came before it.
    if (kind == hslp_pkg::LsDone && !ctx_i.end_valid) begin
      end_n = byte_off_i;
    end
  end

  always_comb begin
    result_o.kind = kind;
    if (kind == hslp_pkg::LsBad) begin
      result_o.code = '0;
      res_start_o   = '0;
      res_end_o     = '0;
    end else begin
      result_o.code = ctx_n.status;
      res_start_o   = first_n;
      res_end_o     = end_n;
    end
  end

  always_comb begin
    if (kind != hslp_pkg::LsMore) begin
      ctx_o.phase     = hslp_pkg::PhStart;
      ctx_o.status    = '0;
      ctx_o.count     = '0;
      ctx_o.end_valid = 1'b0;
      byte_off_o      = '0;
      first_off_o     = '0;
      end_off_o       = '0;
    end else begin
      ctx_o       = ctx_n;
      first_off_o = first_n;
      end_off_o   = end_n;
      if (byte_off_i != {OFFSET_BITS{1'b1}}) byte_off_o = byte_off_i + 1'b1;
      else byte_off_o = byte_off_i;
    end
  end

endmodule

// ===== rtl/core/http_status_line_parser.sv =====
// Top level of the HTTP response status line parser.
//
// The block takes one word, a byte of an HTTP response status line, on the
// input channel (in_valid_i, in_stall_o, data_byte_i) and returns exactly one
// result word per byte on the output channel (out_valid_o, out_stall_i, and
// the four result fields). The result kind tells whether more bytes are
// needed, the line is complete, or the byte made the line malformed. After a
// complete or malformed result the parser starts over on a fresh line.
// A byte is taken into an input register when it is accepted, passes through
// the combinational parser step and is written into the result register once
// that register is free, so a stalled receiver holds it in the input register.
// One byte is accepted every cycle while the receiver does not stall; the
// single-byte parser step against the line context sets that rate.
// Reset clears the line context and both valid flags. When the receiver
// stalls, the result register holds its word; one more byte can still be
// accepted into the input register, after which in_stall_o rises until the
// result word is taken. Offsets count bytes from the start of the line,
// saturate at 2**OFFSET_BITS - 1 and are reported in their low 16 bits.
module http_status_line_parser #(
  parameter int unsigned OFFSET_BITS = hslp_pkg::OffsetBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  line_status_o,
  output logic [9:0]  status_code_o,
  output logic [15:0] status_start_offset_o,
  output logic [15:0] status_end_offset_o
);

  // Input register stage.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;

  // Line context, updated each time a byte moves into the result register.
  hslp_pkg::ctx_t         ctx_q, ctx_d;
  logic [OFFSET_BITS-1:0] byte_off_q, byte_off_d;
  logic [OFFSET_BITS-1:0] first_off_q, first_off_d;
  logic [OFFSET_BITS-1:0] end_off_q, end_off_d;

  // Result register.
  logic                                  out_valid_q, out_valid_d;
  hslp_pkg::result_t                     result_q;
  logic [hslp_pkg::OutOffsetBits-1:0]    start_q;
  logic [hslp_pkg::OutOffsetBits-1:0]    end_q;

  hslp_pkg::result_t      step_result;
  logic [OFFSET_BITS-1:0] step_start;
  logic [OFFSET_BITS-1:0] step_end;

  logic in_accept;
  logic advance;
  logic out_free;

  // The result register can take a new word when empty or being emptied.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  hslp_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .ctx_i       (ctx_q),
    .byte_off_i  (byte_off_q),
    .first_off_i (first_off_q),
    .end_off_i   (end_off_q),
    .data_i      (in_byte_q),
    .ctx_o       (ctx_d),
    .byte_off_o  (byte_off_d),
    .first_off_o (first_off_d),
    .end_off_o   (end_off_d),
    .result_o    (step_result),
    .res_start_o (step_start),
    .res_end_o   (step_end)
  );

  always_comb begin
    if (in_accept) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    else in_valid_d = in_valid_q;
  end

  always_comb begin
    if (advance) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.phase     <= hslp_pkg::PhStart;
      ctx_q.status    <= '0;
      ctx_q.count     <= '0;
      ctx_q.end_valid <= 1'b0;
      byte_off_q      <= '0;
      first_off_q     <= '0;
      end_off_q       <= '0;
    end else if (advance) begin
      ctx_q       <= ctx_d;
      byte_off_q  <= byte_off_d;
      first_off_q <= first_off_d;
      end_off_q   <= end_off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= step_result;
      start_q  <= hslp_pkg::OutOffsetBits'(step_start);
      end_q    <= hslp_pkg::OutOffsetBits'(step_end);
    end
  end

  assign out_valid_o           = out_valid_q;
  assign line_status_o         = result_q.kind;
  assign status_code_o         = result_q.code;
  assign status_start_offset_o = start_q;
  assign status_end_offset_o   = end_q;

  // A finished or malformed line leaves the context cleared for the next one.
  a_clear_after_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step_result.kind != hslp_pkg::LsMore
      |=> ctx_q.phase == hslp_pkg::PhStart && byte_off_q == '0 && ctx_q.count == 2'd0)
    else $error("line context not cleared after end of line");

  // Waiting for the text after the status means all three digits were taken.
  a_digits_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctx_q.phase == hslp_pkg::PhAfterStatus |-> ctx_q.count == hslp_pkg::StatusDigits)
    else $error("status digits incomplete after status field");

  // A malformed result reports no code and no offsets.
  a_bad_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.kind == hslp_pkg::LsBad
      |-> result_q.code == '0 && start_q == '0 && end_q == '0)
    else $error("malformed result carries data");

  // The input stage only pushes back while it holds a byte it cannot pass on.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked byte");

  // Three decimal digits never exceed 999.
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> result_q.code <= 10'd999)
    else $error("status code out of range");

endmodule
